// File: hw/rtl/two_level_propensity_sampler_macros.svh
// Assertion macros shared by the two-level propensity sampler RTL.
// Included by the top sampler module, which carries the concurrent checks; depends on nothing.
`ifndef TWO_LEVEL_PROPENSITY_SAMPLER_MACROS_SVH
`define TWO_LEVEL_PROPENSITY_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TLPS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sampler check failed in the same cycle");

// Next-cycle implication, disabled while reset is high.
`define TLPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sampler check failed in the following cycle");

`endif

// File: hw/rtl/tlps_pkg.sv
// Shared types and constants of the two-level propensity sampler.
// Used by every module of the block; depends on nothing.
package tlps_pkg;

   localparam int MAX_GROUPS_DEFAULT   = 64;
   localparam int MAX_PARTNERS_DEFAULT = 64;
   localparam int WEIGHT_BITS_DEFAULT  = 32;

   localparam int VALUE_W  = 32;
   localparam int ORDER_W  = 6;
   localparam int ROWLEN_W = 7;
   localparam int COUNT_W  = 32;
   localparam int REACT_W  = 12;
   localparam int POS_W    = 6;
   localparam int GC_W     = 7;
   localparam int MODE_W   = 3;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [MODE_W-1:0] {
      MODE_SAMPLE         = 3'd0,
      MODE_GROUP_WEIGHT   = 3'd1,
      MODE_GROUP_ORDER    = 3'd2,
      MODE_PARTNER_WEIGHT = 3'd3,
      MODE_PARTNER_ORDER  = 3'd4,
      MODE_ROW_LENGTH     = 3'd5,
      MODE_MEMBER_COUNT   = 3'd6,
      MODE_REACTION       = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GROUP_SCAN,
      ST_DIVIDE,
      ST_PARTNER_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               valid;
      mode_type           mode;
      logic [VALUE_W-1:0] value;
   } mem_write_type;

endpackage

// File: hw/rtl/two_level_propensity_sampler.sv
// Two-level propensity sampler: a sample item runs a group scan, a residual divide, a partner
// scan and a result emit, and a new item is accepted only in idle, once the result has been
// loaded into the response register. The scans read order and weight memories one entry a
// cycle. A table write item is also accepted only in idle.
// Synchronous reset clears control and sets group_count to 1; the tables are not cleared.
`include "two_level_propensity_sampler_macros.svh"

module two_level_propensity_sampler
   import tlps_pkg::*;
#(
   parameter int MAX_GROUPS   = MAX_GROUPS_DEFAULT,
   parameter int MAX_PARTNERS = MAX_PARTNERS_DEFAULT,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // row_index[5:0], col_index[11:6], entry_value[43:12], uniform_draw[75:44],
   // total_weight[107:76], zero fill[111:108]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[2:0]
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // group_position[5:0], partner_position[11:6], reaction_id[23:12]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // overrun[0]
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_we,
   input  logic [GC_W-1:0]       csr_wdata
);

   localparam int GW    = $clog2(MAX_GROUPS);
   localparam int PW    = $clog2(MAX_PARTNERS);
   localparam int IW    = (GW > PW) ? GW : PW;
   localparam int AW    = $clog2(MAX_GROUPS * MAX_PARTNERS);
   localparam int LEN_W = 11;
   localparam int SUM_W = 64;

   function automatic logic [ORDER_W-1:0] wrap_order(input logic [ORDER_W-1:0] value,
                                                     input int unsigned modulus);
      logic [ORDER_W-1:0] rest;
      int unsigned        step;
      rest = value;
      for (int s = ORDER_W - 1; s >= 0; s--) begin
         step = modulus << s;
         if (32'(rest) >= step) begin
            rest = rest - ORDER_W'(step);
         end
      end
      return rest;
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [GW-1:0] r, input logic [PW-1:0] c);
      return AW'(r) * AW'(MAX_PARTNERS) + AW'(c);
   endfunction

   mode_type               req_mode;
   logic [5:0]             req_row;
   logic [5:0]             req_col;
   logic [VALUE_W-1:0]     req_value;
   logic [VALUE_W-1:0]     req_draw;
   logic [VALUE_W-1:0]     req_total;
   logic                   req_accept;
   logic                   sample_accept;
   logic                   write_accept;
   logic                   row_ok;
   logic                   col_ok;
   logic [2*VALUE_W-1:0]   product;

   state_type              state_ff, state_in;
   logic                   stage_one;
   logic                   stage_two;
   logic                   emit_load;

   logic [GC_W-1:0]        group_count_ff, group_count_in;
   logic [VALUE_W-1:0]     target_ff, target_in;
   logic                   scan_issue_ff, scan_issue_in;
   logic [IW-1:0]          issue_idx_ff, issue_idx_in;
   logic [IW-1:0]          last_idx_ff, last_idx_in;
   logic                   empty_ff, empty_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic                   p1_valid_ff, p1_valid_in;
   logic [IW-1:0]          p1_idx_ff, p1_idx_in;
   logic                   p2_valid_ff, p2_valid_in;
   logic [IW-1:0]          p2_idx_ff, p2_idx_in;
   logic [IW-1:0]          p2_key_ff, p2_key_in;
   logic [POS_W-1:0]       gpos_ff, gpos_in;
   logic [GW-1:0]          grp_ff, grp_in;
   logic [ROWLEN_W-1:0]    rowlen_ff, rowlen_in;
   logic                   count_zero_ff, count_zero_in;
   logic [SUM_W-1:0]       scaled_ff, scaled_in;
   logic [POS_W-1:0]       ppos_ff, ppos_in;
   logic [REACT_W-1:0]     reaction_ff, reaction_in;
   logic                   over_ff, over_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                   rsp_over_ff, rsp_over_in;

   logic [LEN_W-1:0]       g_len;
   logic [LEN_W-1:0]       p_len;
   logic                   g_empty;
   logic                   p_empty;
   logic [IW-1:0]          g_last;
   logic [IW-1:0]          p_last;
   logic [IW-1:0]          key_wrap;
   logic [WEIGHT_BITS-1:0] weight_rd;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       acc_sum;
   logic [SUM_W-1:0]       cmp_value;
   logic                   hit;
   logic                   at_last;
   logic                   scan_finish;
   logic [VALUE_W-1:0]     resid;
   logic                   scan_quiet;
   logic                   pipe_empty;
   logic                   scan_started;

   mem_write_type          gm_wr;
   mem_write_type          pm_wr;
   logic [ORDER_W-1:0]     gm_order_rd;
   logic [WEIGHT_BITS-1:0] gm_weight_rd;
   logic [ROWLEN_W-1:0]    gm_len_rd;
   logic [COUNT_W-1:0]     gm_count_rd;
   logic [ORDER_W-1:0]     pm_order_rd;
   logic [WEIGHT_BITS-1:0] pm_weight_rd;
   logic [REACT_W-1:0]     pm_reaction_rd;
   logic                   div_start;
   logic                   div_done;
   logic [COUNT_W-1:0]     div_quotient;

   assign req_mode  = mode_type'(req_tuser);
   assign req_row   = req_tdata[5:0];
   assign req_col   = req_tdata[11:6];
   assign req_value = req_tdata[43:12];
   assign req_draw  = req_tdata[75:44];
   assign req_total = req_tdata[107:76];

   assign req_accept    = req_tvalid && req_tready;
   assign sample_accept = req_accept && (req_mode == MODE_SAMPLE);
   assign write_accept  = req_accept && (req_mode != MODE_SAMPLE);
   assign row_ok        = LEN_W'(req_row) < LEN_W'(MAX_GROUPS);
   assign col_ok        = LEN_W'(req_col) < LEN_W'(MAX_PARTNERS);
   assign product       = (2*VALUE_W)'(req_draw) * (2*VALUE_W)'(req_total);

   assign gm_wr.valid = write_accept && row_ok;
   assign gm_wr.mode  = req_mode;
   assign gm_wr.value = req_value;
   assign pm_wr.valid = write_accept && row_ok && col_ok;
   assign pm_wr.mode  = req_mode;
   assign pm_wr.value = req_value;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_accept) begin
               state_in = ST_GROUP_SCAN;
            end
         end
         ST_GROUP_SCAN: begin
            if (scan_finish) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_PARTNER_SCAN;
            end
         end
         ST_PARTNER_SCAN: begin
            if (scan_finish) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State decode.
   always_comb begin
      req_tready = 1'b0;
      stage_one  = 1'b0;
      stage_two  = 1'b0;
      emit_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_GROUP_SCAN: begin
            stage_one = 1'b1;
         end
         ST_DIVIDE: begin
         end
         ST_PARTNER_SCAN: begin
            stage_two = 1'b1;
         end
         ST_EMIT: begin
            emit_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // Scan lengths, clamped to the table sizes.
   always_comb begin
      g_len = (LEN_W'(group_count_ff) > LEN_W'(MAX_GROUPS)) ? LEN_W'(MAX_GROUPS)
                                                             : LEN_W'(group_count_ff);
      p_len = (LEN_W'(rowlen_ff) > LEN_W'(MAX_PARTNERS)) ? LEN_W'(MAX_PARTNERS)
                                                          : LEN_W'(rowlen_ff);
      g_empty = g_len == '0;
      p_empty = p_len == '0;
      g_last  = g_empty ? '0 : IW'(g_len - LEN_W'(1));
      p_last  = p_empty ? '0 : IW'(p_len - LEN_W'(1));
   end

   // An empty partner row reports column 0 rather than a sorted entry.
   always_comb begin
      if (stage_one) begin
         key_wrap = IW'(wrap_order(gm_order_rd, MAX_GROUPS));
      end else if (empty_ff) begin
         key_wrap = '0;
      end else begin
         key_wrap = IW'(wrap_order(pm_order_rd, MAX_PARTNERS));
      end
   end

   assign weight_rd   = stage_one ? gm_weight_rd : pm_weight_rd;
   assign sum_wide    = {1'b0, acc_ff} + (SUM_W+1)'(weight_rd);
   assign acc_sum     = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
   assign cmp_value   = stage_one ? SUM_W'(target_ff) : scaled_ff;
   assign hit         = !empty_ff && (cmp_value < acc_sum);
   assign at_last     = p2_idx_ff == last_idx_ff;
   assign scan_finish = p2_valid_ff && (hit || at_last);
   assign resid       = (SUM_W'(target_ff) >= acc_ff) ? VALUE_W'(SUM_W'(target_ff) - acc_ff)
                                                       : '0;
   assign div_start   = stage_one && scan_finish;

   always_comb begin
      group_count_in = csr_we ? csr_wdata : group_count_ff;
      target_in      = target_ff;
      scan_issue_in  = scan_issue_ff;
      issue_idx_in   = issue_idx_ff;
      last_idx_in    = last_idx_ff;
      empty_in       = empty_ff;
      acc_in         = acc_ff;
      p1_valid_in    = scan_issue_ff;
      p1_idx_in      = issue_idx_ff;
      p2_valid_in    = p1_valid_ff;
      p2_idx_in      = p1_idx_ff;
      p2_key_in      = key_wrap;
      gpos_in        = gpos_ff;
      grp_in         = grp_ff;
      rowlen_in      = rowlen_ff;
      count_zero_in  = count_zero_ff;
      scaled_in      = scaled_ff;
      ppos_in        = ppos_ff;
      reaction_in    = reaction_ff;
      over_in        = over_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_over_in    = rsp_over_ff;

      if (scan_issue_ff) begin
         if (issue_idx_ff == last_idx_ff) begin
            scan_issue_in = 1'b0;
         end else begin
            issue_idx_in = issue_idx_ff + 1'b1;
         end
      end
      if (p2_valid_ff) begin
         acc_in = acc_sum;
      end
      if (scan_finish) begin
         scan_issue_in = 1'b0;
         p1_valid_in   = 1'b0;
         p2_valid_in   = 1'b0;
      end

      if (sample_accept) begin
         target_in     = product[2*VALUE_W-1:VALUE_W];
         scan_issue_in = 1'b1;
         issue_idx_in  = '0;
         last_idx_in   = g_last;
         empty_in      = g_empty;
         acc_in        = '0;
      end

      if (stage_one && scan_finish) begin
         gpos_in       = POS_W'(p2_idx_ff);
         grp_in        = GW'(p2_key_ff);
         rowlen_in     = gm_len_rd;
         count_zero_in = gm_count_rd == '0;
         over_in       = !hit;
      end

      if (div_done) begin
         scaled_in     = count_zero_ff ? '1 : SUM_W'(div_quotient);
         scan_issue_in = 1'b1;
         issue_idx_in  = '0;
         last_idx_in   = p_last;
         empty_in      = p_empty;
         acc_in        = '0;
      end

      if (stage_two && scan_finish) begin
         ppos_in     = POS_W'(p2_idx_ff);
         reaction_in = pm_reaction_rd;
         over_in     = over_ff || !hit;
      end

      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {reaction_ff, ppos_ff, gpos_ff};
         rsp_over_in  = over_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         group_count_ff <= GC_W'(1);
         scan_issue_ff  <= 1'b0;
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         group_count_ff <= group_count_in;
         scan_issue_ff  <= scan_issue_in;
         p1_valid_ff    <= p1_valid_in;
         p2_valid_ff    <= p2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      issue_idx_ff  <= issue_idx_in;
      last_idx_ff   <= last_idx_in;
      empty_ff      <= empty_in;
      acc_ff        <= acc_in;
      p1_idx_ff     <= p1_idx_in;
      p2_idx_ff     <= p2_idx_in;
      p2_key_ff     <= p2_key_in;
      gpos_ff       <= gpos_in;
      grp_ff        <= grp_in;
      rowlen_ff     <= rowlen_in;
      count_zero_ff <= count_zero_in;
      scaled_ff     <= scaled_in;
      ppos_ff       <= ppos_in;
      reaction_ff   <= reaction_in;
      over_ff       <= over_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_over_ff   <= rsp_over_in;
   end

   tlps_group_mem #(
      .MAX_GROUPS  (MAX_GROUPS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_group_mem (
      .clock      (clock),
      .wr         (gm_wr),
      .wr_addr    (GW'(req_row)),
      .order_addr (GW'(issue_idx_ff)),
      .order_rd   (gm_order_rd),
      .entry_addr (GW'(key_wrap)),
      .weight_rd  (gm_weight_rd),
      .len_rd     (gm_len_rd),
      .count_rd   (gm_count_rd)
   );

   tlps_partner_mem #(
      .MAX_GROUPS   (MAX_GROUPS),
      .MAX_PARTNERS (MAX_PARTNERS),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_partner_mem (
      .clock       (clock),
      .wr          (pm_wr),
      .wr_addr     (cell_addr(GW'(req_row), PW'(req_col))),
      .order_addr  (cell_addr(grp_ff, PW'(issue_idx_ff))),
      .order_rd    (pm_order_rd),
      .entry_addr  (cell_addr(grp_ff, PW'(key_wrap))),
      .weight_rd   (pm_weight_rd),
      .reaction_rd (pm_reaction_rd)
   );

   tlps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (resid),
      .divisor  (gm_count_rd),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_over_ff;

   assign scan_quiet   = state_ff == ST_IDLE || state_ff == ST_DIVIDE || state_ff == ST_EMIT;
   assign pipe_empty   = !scan_issue_ff && !p1_valid_ff && !p2_valid_ff;
   assign scan_started = state_ff == ST_GROUP_SCAN && scan_issue_ff && issue_idx_ff == '0;

   `TLPS_ASSERT_IMPLIES(a_issue_in_range, clock, reset, scan_issue_ff, issue_idx_ff <= last_idx_ff)
   `TLPS_ASSERT_IMPLIES(a_scan_flushed, clock, reset, scan_quiet, pipe_empty)
   `TLPS_ASSERT_IMPLIES(a_divide_done_in_state, clock, reset, div_done, state_ff == ST_DIVIDE)
   `TLPS_ASSERT_NEXT(a_sample_starts_scan, clock, reset, sample_accept, scan_started)

endmodule

// File: hw/rtl/tlps_group_mem.sv
// Per-group tables: weight, sorted order, row length and member count.
// One write port and registered reads; depends on tlps_pkg.
module tlps_group_mem
   import tlps_pkg::*;
#(
   parameter int MAX_GROUPS  = MAX_GROUPS_DEFAULT,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEFAULT,
   localparam int GW = $clog2(MAX_GROUPS)
) (
   input  logic                   clock,
   input  mem_write_type          wr,
   input  logic [GW-1:0]          wr_addr,
   input  logic [GW-1:0]          order_addr,
   output logic [ORDER_W-1:0]     order_rd,
   input  logic [GW-1:0]          entry_addr,
   output logic [WEIGHT_BITS-1:0] weight_rd,
   output logic [ROWLEN_W-1:0]    len_rd,
   output logic [COUNT_W-1:0]     count_rd
);

   logic [WEIGHT_BITS-1:0] weight_mem [MAX_GROUPS];
   logic [ORDER_W-1:0]     order_mem  [MAX_GROUPS];
   logic [ROWLEN_W-1:0]    len_mem    [MAX_GROUPS];
   logic [COUNT_W-1:0]     count_mem  [MAX_GROUPS];

   logic [ORDER_W-1:0]     order_rd_ff;
   logic [WEIGHT_BITS-1:0] weight_rd_ff;
   logic [ROWLEN_W-1:0]    len_rd_ff;
   logic [COUNT_W-1:0]     count_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         unique case (wr.mode)
            MODE_GROUP_WEIGHT: begin
               weight_mem[wr_addr] <= WEIGHT_BITS'(wr.value);
            end
            MODE_GROUP_ORDER: begin
               order_mem[wr_addr] <= ORDER_W'(wr.value);
            end
            MODE_ROW_LENGTH: begin
               len_mem[wr_addr] <= ROWLEN_W'(wr.value);
            end
            MODE_MEMBER_COUNT: begin
               count_mem[wr_addr] <= COUNT_W'(wr.value);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      order_rd_ff  <= order_mem[order_addr];
      weight_rd_ff <= weight_mem[entry_addr];
      len_rd_ff    <= len_mem[entry_addr];
      count_rd_ff  <= count_mem[entry_addr];
   end

   assign order_rd  = order_rd_ff;
   assign weight_rd = weight_rd_ff;
   assign len_rd    = len_rd_ff;
   assign count_rd  = count_rd_ff;

endmodule

// File: hw/rtl/tlps_partner_mem.sv
// Per-cell tables of every group row: partner weight, sorted order, reaction id.
// One write port and registered reads; depends on tlps_pkg.
module tlps_partner_mem
   import tlps_pkg::*;
#(
   parameter int MAX_GROUPS   = MAX_GROUPS_DEFAULT,
   parameter int MAX_PARTNERS = MAX_PARTNERS_DEFAULT,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEFAULT,
   localparam int DEPTH = MAX_GROUPS * MAX_PARTNERS,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  mem_write_type          wr,
   input  logic [AW-1:0]          wr_addr,
   input  logic [AW-1:0]          order_addr,
   output logic [ORDER_W-1:0]     order_rd,
   input  logic [AW-1:0]          entry_addr,
   output logic [WEIGHT_BITS-1:0] weight_rd,
   output logic [REACT_W-1:0]     reaction_rd
);

   logic [WEIGHT_BITS-1:0] weight_mem   [DEPTH];
   logic [ORDER_W-1:0]     order_mem    [DEPTH];
   logic [REACT_W-1:0]     reaction_mem [DEPTH];

   logic [ORDER_W-1:0]     order_rd_ff;
   logic [WEIGHT_BITS-1:0] weight_rd_ff;
   logic [REACT_W-1:0]     reaction_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         unique case (wr.mode)
            MODE_PARTNER_WEIGHT: begin
               weight_mem[wr_addr] <= WEIGHT_BITS'(wr.value);
            end
            MODE_PARTNER_ORDER: begin
               order_mem[wr_addr] <= ORDER_W'(wr.value);
            end
            MODE_REACTION: begin
               reaction_mem[wr_addr] <= REACT_W'(wr.value);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      order_rd_ff    <= order_mem[order_addr];
      weight_rd_ff   <= weight_mem[entry_addr];
      reaction_rd_ff <= reaction_mem[entry_addr];
   end

   assign order_rd    = order_rd_ff;
   assign weight_rd   = weight_rd_ff;
   assign reaction_rd = reaction_rd_ff;

endmodule

// File: hw/rtl/tlps_divider.sv
// Restoring divider, one quotient bit per cycle, for the residual scaling.
// A zero divisor yields all ones; depends on tlps_pkg.
module tlps_divider
   import tlps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [COUNT_W-1:0] dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [COUNT_W-1:0] quotient
);

   localparam int STEP_W = $clog2(COUNT_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [COUNT_W-1:0]  quo_ff, quo_in;
   logic [COUNT_W-1:0]  den_ff, den_in;
   logic [COUNT_W:0]    shifted;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[COUNT_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         steps_in = STEP_W'(COUNT_W);
         rem_in   = '0;
         quo_in   = dividend;
         den_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? COUNT_W'(shifted - {1'b0, den_ff}) : COUNT_W'(shifted);
         quo_in   = {quo_ff[COUNT_W-2:0], fits};
         steps_in = steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         steps_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         steps_ff <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: dv/two_level_propensity_sampler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-level propensity sampler: preloads the tables of a few
// active groups, then drives directed and random load and sample items with random stalls.
// Depends on tlps_pkg and the two_level_propensity_sampler RTL.
module two_level_propensity_sampler_tb;
   import tlps_pkg::*;

   localparam int TABLE_SIZE    = 64;
   localparam int ACTIVE_GROUPS = 3;
   localparam int ACTIVE_COLS   = 6;
   localparam int COL_STRIDE    = 11;
   localparam int SETTLE        = 8;
   localparam int LONG_HOLD     = 3000;
   localparam int IDLE_LIMIT    = 20000;
   localparam int RANDOM_ITEMS  = 540;

   typedef struct packed {
      bit               overrun;
      bit [REACT_W-1:0] reaction_id;
      bit [POS_W-1:0]   partner_position;
      bit [POS_W-1:0]   group_position;
   } pick_type;

   class pick_scoreboard;
      bit [GC_W-1:0]     scan_groups;
      bit [31:0]         group_wt [TABLE_SIZE];
      bit [ORDER_W-1:0]  group_rank [TABLE_SIZE];
      bit [ROWLEN_W-1:0] row_len [TABLE_SIZE];
      bit [COUNT_W-1:0]  members [TABLE_SIZE];
      bit [31:0]         partner_wt [TABLE_SIZE][TABLE_SIZE];
      bit [ORDER_W-1:0]  partner_rank [TABLE_SIZE][TABLE_SIZE];
      bit [REACT_W-1:0]  reaction [TABLE_SIZE][TABLE_SIZE];
      pick_type          expected_picks [$];
      int                failures;

      function new();
         scan_groups = 1;
         failures = 0;
      endfunction

      function pick_type draw_reaction(bit [31:0] draw, bit [31:0] total);
         pick_type         pick;
         bit [63:0]        target, prefix, acc, scaled;
         int               span, len;
         bit               hit;
         bit [ORDER_W-1:0] grp, pcol;
         pick = '0;
         target = ({32'd0, draw} * {32'd0, total}) >> 32;
         span = (scan_groups > TABLE_SIZE) ? TABLE_SIZE : int'(scan_groups);
         prefix = 0;
         acc = 0;
         hit = 1'b0;
         for (int i = 0; i < span && !hit; i++) begin
            prefix = acc;
            acc += 64'(group_wt[group_rank[i]]);
            pick.group_position = POS_W'(i);
            hit = target < acc;
         end
         pick.overrun = !hit;
         grp = group_rank[pick.group_position];
         scaled = (members[grp] != 0) ? (target - prefix) / 64'(members[grp]) : '1;
         len = (row_len[grp] > TABLE_SIZE) ? TABLE_SIZE : int'(row_len[grp]);
         acc = 0;
         hit = 1'b0;
         pcol = 0;
         for (int j = 0; j < len && !hit; j++) begin
            pcol = partner_rank[grp][j];
            acc += 64'(partner_wt[grp][pcol]);
            pick.partner_position = POS_W'(j);
            hit = scaled < acc;
         end
         if (!hit) pick.overrun = 1'b1;
         pick.reaction_id = reaction[grp][pcol];
         return pick;
      endfunction

      function void note_item(mode_type mode, bit [5:0] row, bit [5:0] col, bit [31:0] value,
                              bit [31:0] draw, bit [31:0] total);
         case (mode)
            MODE_SAMPLE:         expected_picks.push_back(draw_reaction(draw, total));
            MODE_GROUP_WEIGHT:   group_wt[row] = value;
            MODE_GROUP_ORDER:    group_rank[row] = value[ORDER_W-1:0];
            MODE_PARTNER_WEIGHT: partner_wt[row][col] = value;
            MODE_PARTNER_ORDER:  partner_rank[row][col] = value[ORDER_W-1:0];
            MODE_ROW_LENGTH:     row_len[row] = value[ROWLEN_W-1:0];
            MODE_MEMBER_COUNT:   members[row] = value;
            MODE_REACTION:       reaction[row][col] = value[REACT_W-1:0];
            default: ;
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_pick(logic [RSP_DATA_W-1:0] data, logic overrun);
         pick_type want;
         if (expected_picks.size() == 0) begin
            $error("result with no sample outstanding: rsp_tdata %h", data);
            failures++;
            return;
         end
         want = expected_picks.pop_front();
         compare_field("group_position", want.group_position, data[5:0]);
         compare_field("partner_position", want.partner_position, data[11:6]);
         compare_field("reaction_id", want.reaction_id, data[23:12]);
         compare_field("overrun", want.overrun, overrun);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [0:0]            rsp_tuser;
   logic                  csr_we = 1'b0;
   logic [GC_W-1:0]       csr_wdata = '0;

   pick_scoreboard sb = new();
   int             items_sent = 0;
   int             idle_cycles = 0;
   bit             steady = 1'b1;
   bit             long_hold_due = 1'b0;
   int             slot_perm [TABLE_SIZE];
   bit [5:0]       active_grp [ACTIVE_GROUPS];

   two_level_propensity_sampler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int gap_length();
      return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
                                         : int'($urandom_range(8, 60));
   endfunction

   function automatic bit [31:0] fit32(bit [63:0] value);
      return (value > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : value[31:0];
   endfunction

   function automatic bit [31:0] fresh_partner_weight();
      return ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(0, 65535));
   endfunction

   // Columns that hold partner weights and reaction ids; column 0 is among them.
   function automatic bit [5:0] col_of(int k);
      return 6'(k * COL_STRIDE);
   endfunction

   function automatic bit [5:0] any_active_group();
      return active_grp[$urandom_range(0, ACTIVE_GROUPS - 1)];
   endfunction

   function automatic bit [63:0] span_of(int positions);
      bit [63:0] acc;
      acc = 0;
      for (int i = 0; i < positions; i++) acc += 64'(sb.group_wt[sb.group_rank[i]]);
      return acc;
   endfunction

   function automatic void shuffle_slots();
      int j, keep;
      for (int i = 0; i < TABLE_SIZE; i++) slot_perm[i] = i;
      for (int i = TABLE_SIZE - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         keep = slot_perm[i];
         slot_perm[i] = slot_perm[j];
         slot_perm[j] = keep;
      end
   endfunction

   task automatic send_item(mode_type mode, bit [5:0] row, bit [5:0] col, bit [31:0] value,
                            bit [31:0] draw, bit [31:0] total);
      int idle;
      idle = (!steady && $urandom_range(0, 99) < 25) ? gap_length() : 0;
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'd0, total, draw, value, col, row};
      do @(posedge clock); while (!req_tready);
      sb.note_item(mode, row, col, value, draw, total);
      items_sent++;
   endtask

   task automatic write_entry(mode_type mode, bit [5:0] row, bit [5:0] col, bit [31:0] value);
      send_item(mode, row, col, value, $urandom, $urandom);
   endtask

   // Order entries always point at rows and columns that hold data.
   task automatic random_write();
      mode_type  mode;
      bit [31:0] value;
      mode = mode_type'(3'($urandom_range(1, 7)));
      value = $urandom;
      if (mode == MODE_GROUP_ORDER) begin
         value = (value & 32'hFFFF_FFC0) | 32'(any_active_group());
      end else if (mode == MODE_PARTNER_ORDER) begin
         value = (value & 32'hFFFF_FFC0) | 32'(col_of($urandom_range(0, ACTIVE_COLS - 1)));
      end
      write_entry(mode, 6'($urandom), 6'($urandom), value);
   endtask

   task automatic sample_with(bit [31:0] draw, bit [31:0] total);
      send_item(MODE_SAMPLE, 6'($urandom), 6'($urandom), $urandom, draw, total);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_picks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_group_count(bit [GC_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.scan_groups = value;
   endtask

   // Gives a group a fresh count and row length and a group weight that matches its
   // partner weights, so that samples landing in it resolve inside its row.
   task automatic rebuild_group(bit [5:0] grp, int touches);
      bit [63:0] acc;
      bit [31:0] count;
      int        len;
      repeat (touches) begin
         write_entry(MODE_PARTNER_WEIGHT, grp, col_of($urandom_range(0, ACTIVE_COLS - 1)),
                     fresh_partner_weight());
      end
      count = $urandom_range(1, 4);
      len = $urandom_range(1, TABLE_SIZE);
      write_entry(MODE_MEMBER_COUNT, grp, 6'($urandom), count);
      write_entry(MODE_ROW_LENGTH, grp, 6'($urandom), 32'(len));
      acc = 0;
      for (int j = 0; j < len; j++) acc += 64'(sb.partner_wt[grp][sb.partner_rank[grp][j]]);
      write_entry(MODE_GROUP_WEIGHT, grp, 6'($urandom), fit32(acc * count));
   endtask

   task automatic send_sample();
      bit [63:0] span;
      bit [31:0] draw, total;
      int        positions, roll;
      positions = (sb.scan_groups > TABLE_SIZE) ? TABLE_SIZE : int'(sb.scan_groups);
      span = span_of(positions);
      draw = $urandom;
      if (draw == 0) draw = 1;
      total = fit32(span);
      roll = $urandom_range(0, 99);
      if (roll >= 70 && roll < 82) begin
         total = $urandom;
      end else if (roll >= 82 && roll < 92 && positions > 0) begin
         // The target lands exactly on a running sum, so the scan must step past it.
         draw = 32'h8000_0000;
         total = fit32(span_of($urandom_range(1, positions)) << 1);
      end else if (roll >= 92) begin
         draw = 32'hFFFF_FFFF;
         total = fit32(span + (span >> 3) + 1);
      end
      sample_with(draw, total);
   endtask

   initial begin : rsp_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            hold = LONG_HOLD;
            long_hold_due = 1'b0;
         end else if (hold == 0 && !steady && $urandom_range(0, 99) < 20) begin
            hold = gap_length();
         end
         rsp_tready <= (hold == 0);
         if (hold > 0) hold--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_pick(rsp_tdata, rsp_tuser[0]);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL two_level_propensity_sampler");
         $finish;
      end
   end

   initial begin : stimulus
      int         random_start, roll, positions;
      bit         hold_armed;
      bit [5:0]   g0;
      hold_armed = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Every entry that a sample can reach is written before the first sample item.
      steady = 1'b1;
      shuffle_slots();
      for (int k = 0; k < ACTIVE_GROUPS; k++) active_grp[k] = 6'(slot_perm[k]);
      for (int k = 0; k < ACTIVE_GROUPS; k++) begin
         for (int c = 0; c < ACTIVE_COLS; c++) begin
            write_entry(MODE_PARTNER_WEIGHT, active_grp[k], col_of(c), fresh_partner_weight());
            write_entry(MODE_REACTION, active_grp[k], col_of(c), $urandom);
         end
         for (int j = 0; j < TABLE_SIZE; j++) begin
            write_entry(MODE_PARTNER_ORDER, active_grp[k], 6'(j),
                        32'(col_of($urandom_range(0, ACTIVE_COLS - 1))));
         end
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
         write_entry(MODE_GROUP_ORDER, 6'(i), 6'($urandom), 32'(any_active_group()));
      end
      for (int k = 0; k < ACTIVE_GROUPS; k++) rebuild_group(active_grp[k], 0);

      steady = 1'b0;
      g0 = sb.group_rank[0];
      sample_with(32'd1, 32'd0);
      sample_with(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      sample_with(32'h8000_0000, fit32(64'(sb.group_wt[g0]) << 1));
      write_entry(MODE_GROUP_ORDER, 6'd0, 6'd63, 32'hFFFF_FFC0 | 32'(g0));
      write_entry(MODE_PARTNER_ORDER, g0, 6'd0, 32'hFFFF_FFC0 | 32'(sb.partner_rank[g0][0]));
      // A member count of zero forces the partner scan to run off its end.
      write_entry(MODE_MEMBER_COUNT, g0, 6'd0, 32'd0);
      sample_with(32'h4000_0000, sb.group_wt[g0]);
      write_entry(MODE_ROW_LENGTH, g0, 6'd0, 32'd0);
      sample_with(32'h4000_0000, sb.group_wt[g0]);
      // A row length beyond the table is clamped to the full row.
      write_entry(MODE_ROW_LENGTH, g0, 6'd0, 32'hFFFF_FFFF);
      write_entry(MODE_MEMBER_COUNT, g0, 6'd0, 32'd1);
      write_entry(MODE_GROUP_WEIGHT, g0, 6'd0, 32'hFFFF_FFFF);
      sample_with(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_entry(MODE_PARTNER_WEIGHT, 6'd63, 6'd63, 32'hFFFF_FFFF);
      write_entry(MODE_REACTION, 6'd63, 6'd63, 32'hFFFF_FFFF);
      write_entry(MODE_REACTION, 6'd0, 6'd0, 32'd0);
      rebuild_group(g0, 0);
      set_group_count(7'd0);
      send_sample();
      set_group_count(7'd127);
      send_sample();
      set_group_count(7'd64);
      send_sample();

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 19);
         if (roll < 2) set_group_count(7'd64);
         else if (roll < 3) set_group_count(7'd0);
         else if (roll < 4) set_group_count(7'($urandom_range(65, 127)));
         else if (roll < 6) set_group_count(7'd1);
         else set_group_count(7'($urandom_range(2, 63)));
         steady = ($urandom_range(0, 3) == 0);
         if (!hold_armed && items_sent - random_start > RANDOM_ITEMS / 3) begin
            long_hold_due = 1'b1;
            hold_armed = 1'b1;
         end
         positions = (sb.scan_groups > TABLE_SIZE) ? TABLE_SIZE : int'(sb.scan_groups);
         repeat ($urandom_range(30, 70)) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               send_sample();
            end else if (roll < 75) begin
               rebuild_group((positions > 0) ? sb.group_rank[$urandom_range(0, positions - 1)]
                                             : any_active_group(), $urandom_range(0, 4));
            end else begin
               random_write();
            end
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.failures == 0) $display("PASS two_level_propensity_sampler");
      else $display("FAIL two_level_propensity_sampler");
      $finish;
   end

endmodule
